### sv/itm_pkg.sv
// ----------------------------------------------------------------------------
// itm_pkg: shared types and constants for the idle time monitor
// Phase codes, controller states, result field widths and the command and
// status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package itm_pkg;

    localparam int unsigned DataW    = 32;
    localparam int unsigned RoundsW  = 8;
    localparam int unsigned DelayW   = 10;
    localparam int unsigned PctW     = 16;
    localparam int unsigned DivCntW  = $clog2(DataW);

    localparam logic [RoundsW-1:0] RoundsReset = 8'd3;

    localparam logic [DelayW-1:0] DelayShort = 10'd1;
    localparam logic [DelayW-1:0] DelayAlign = 10'd100;
    localparam logic [DelayW-1:0] DelayLong  = 10'd1000;

    localparam logic [DataW-1:0] PercentScale = 32'd100;

    // Phase of the calibration and sampling sequence
    typedef enum logic [1:0] {
        PH_ALIGN   = 2'd0,
        PH_MEASURE = 2'd1,
        PH_SAMPLE  = 2'd2
    } phase_t;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL1,
        ST_DIV1_INIT,
        ST_DIV1,
        ST_MUL2,
        ST_DIV2_INIT,
        ST_DIV2,
        ST_WRITE
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic              capture;    // take input, update prev and deltas
        logic              calib_load; // deltas of this transaction become calibration
        logic              mul_go;     // load product register
        logic              mul_sel;    // 0: ds * calib_interval, 1: quotient * 100
        logic              div_start;  // load divider from product register
        logic              div_sel;    // 0: divide by dt, 1: divide by calib_spins
        logic              div_step;   // one restoring division step
        logic              out_load;   // load result register
        logic [DelayW-1:0] delay;
        logic              done;
        phase_t            seen;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic fault;    // sample interval or calib_spins is zero
        logic div_last; // final division step in progress
        logic out_free; // result register can take a new result
    } sts_t;

endpackage

### sv/itm_dpath.sv
// ----------------------------------------------------------------------------
// itm_dpath: idle time monitor datapath
// Holds previous and calibration samples, a 32x32 multiplier with product
// register, a one-bit-per-cycle restoring divider and the result register.
// ----------------------------------------------------------------------------
module itm_dpath (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [63:0]         s_tdata,
    input  itm_pkg::cmd_t       cmd,
    output itm_pkg::sts_t       sts,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [31:0]         m_tdata
);
    import itm_pkg::*;

    logic [DataW-1:0] in_spins;
    logic [DataW-1:0] in_time;
    logic [DataW-1:0] prev_spins_reg;
    logic [DataW-1:0] prev_time_reg;
    logic [DataW-1:0] calib_spins_reg;
    logic [DataW-1:0] calib_interval_reg;
    logic [DataW-1:0] ds_reg;
    logic [DataW-1:0] dt_reg;
    logic [DataW-1:0] ds_next;
    logic [DataW-1:0] dt_next;
    logic [DataW-1:0] mul_a;
    logic [DataW-1:0] mul_b;
    logic [DataW-1:0] prod_reg;
    logic [DataW-1:0] quo_reg;
    logic [DataW-1:0] rem_reg;
    logic [DataW-1:0] divisor_reg;
    logic [DivCntW-1:0] div_cnt_reg;
    logic [DataW:0]   shifted;
    logic [DataW:0]   trial;
    logic             out_valid_reg;
    logic [31:0]      out_data_reg;
    logic             pct_ok;
    logic [PctW-1:0]  pct;

    assign in_spins = s_tdata[31:0];
    assign in_time  = s_tdata[63:32];
    assign ds_next  = in_spins - prev_spins_reg;
    assign dt_next  = in_time - prev_time_reg;

    // Sample history and calibration deltas
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_spins_reg     <= '0;
            prev_time_reg      <= '0;
            calib_spins_reg    <= '0;
            calib_interval_reg <= '0;
        end
        else if (cmd.capture)
        begin
            prev_spins_reg <= in_spins;
            prev_time_reg  <= in_time;
            if (cmd.calib_load)
            begin
                calib_spins_reg    <= ds_next;
                calib_interval_reg <= dt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            ds_reg <= ds_next;
            dt_reg <= dt_next;
        end
    end

    // Shared multiplier, low 32 bits kept
    assign mul_a = cmd.mul_sel ? quo_reg : ds_reg;
    assign mul_b = cmd.mul_sel ? PercentScale : calib_interval_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.mul_go)
        begin
            prod_reg <= mul_a * mul_b;
        end
    end

    // Restoring divider, one quotient bit per cycle
    assign shifted = {rem_reg, quo_reg[DataW-1]};
    assign trial   = shifted - {1'b0, divisor_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            quo_reg     <= prod_reg;
            rem_reg     <= '0;
            divisor_reg <= cmd.div_sel ? calib_spins_reg : dt_reg;
            div_cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            div_cnt_reg <= div_cnt_reg + 1'b1;
            if (!trial[DataW])
            begin
                rem_reg <= trial[DataW-1:0];
                quo_reg <= {quo_reg[DataW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted[DataW-1:0];
                quo_reg <= {quo_reg[DataW-2:0], 1'b0};
            end
        end
    end

    assign sts.fault    = (dt_reg == '0) || (calib_spins_reg == '0);
    assign sts.div_last = (div_cnt_reg == DivCntW'(DataW - 1));
    assign sts.out_free = !out_valid_reg || m_tready;

    // Result register
    assign pct_ok = (cmd.seen == PH_SAMPLE) && !sts.fault;
    assign pct    = pct_ok ? quo_reg[PctW-1:0] : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_data_reg <= {1'b0, cmd.seen, cmd.done,
                             ((cmd.seen == PH_SAMPLE) && sts.fault),
                             pct_ok, pct, cmd.delay};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

### sv/itm_ctrl.sv
// ----------------------------------------------------------------------------
// itm_ctrl: idle time monitor controller
// Tracks phase and remaining calibration rounds, and sequences the multiply
// and divide steps of a periodic sample.
// ----------------------------------------------------------------------------
module itm_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic                          cfg_we,
    input  logic [itm_pkg::RoundsW-1:0]   cfg_wdata,
    output itm_pkg::cmd_t                 cmd,
    input  itm_pkg::sts_t                 sts
);
    import itm_pkg::*;

    state_t              state_reg, state_next;
    phase_t              phase_reg, phase_next;
    logic [RoundsW-1:0]  rounds_reg, rounds_next;
    logic [DelayW-1:0]   delay_reg, delay_next;
    logic                done_reg, done_next;
    phase_t              seen_reg, seen_next;
    logic [RoundsW-1:0]  rounds_dec;

    assign rounds_dec = rounds_reg - 1'b1;

    // State and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            phase_reg  <= PH_ALIGN;
            rounds_reg <= RoundsReset;
            delay_reg  <= DelayAlign;
            done_reg   <= 1'b0;
            seen_reg   <= PH_ALIGN;
        end
        else
        begin
            state_reg  <= state_next;
            phase_reg  <= phase_next;
            rounds_reg <= rounds_next;
            delay_reg  <= delay_next;
            done_reg   <= done_next;
            seen_reg   <= seen_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        rounds_next = rounds_reg;
        delay_next  = delay_reg;
        done_next   = done_reg;
        seen_next   = seen_reg;
        s_tready    = 1'b0;

        cmd            = '0;
        cmd.delay      = delay_reg;
        cmd.done       = done_reg;
        cmd.seen       = seen_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    unique case (phase_reg)
                        PH_MEASURE:
                        begin
                            cmd.calib_load = 1'b1;
                            seen_next      = PH_MEASURE;
                            rounds_next    = rounds_dec;
                            if (rounds_dec != '0)
                            begin
                                phase_next = PH_ALIGN;
                                delay_next = DelayShort;
                                done_next  = 1'b0;
                            end
                            else
                            begin
                                phase_next = PH_SAMPLE;
                                delay_next = DelayLong;
                                done_next  = 1'b1;
                            end
                            state_next = ST_WRITE;
                        end
                        PH_SAMPLE:
                        begin
                            seen_next  = PH_SAMPLE;
                            delay_next = DelayLong;
                            done_next  = 1'b0;
                            state_next = ST_MUL1;
                        end
                        default:
                        begin
                            seen_next  = PH_ALIGN;
                            delay_next = DelayAlign;
                            done_next  = 1'b0;
                            phase_next = PH_MEASURE;
                            state_next = ST_WRITE;
                        end
                    endcase
                end
            end
            ST_MUL1:
            begin
                cmd.mul_go  = 1'b1;
                cmd.mul_sel = 1'b0;
                state_next  = sts.fault ? ST_WRITE : ST_DIV1_INIT;
            end
            ST_DIV1_INIT:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = 1'b0;
                state_next    = ST_DIV1;
            end
            ST_DIV1:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = ST_MUL2;
                end
            end
            ST_MUL2:
            begin
                cmd.mul_go  = 1'b1;
                cmd.mul_sel = 1'b1;
                state_next  = ST_DIV2_INIT;
            end
            ST_DIV2_INIT:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = 1'b1;
                state_next    = ST_DIV2;
            end
            ST_DIV2:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Register write reloads the round count
        if (cfg_we)
        begin
            rounds_next = cfg_wdata;
        end
    end

endmodule

### sv/idle_time_monitor.sv
// ----------------------------------------------------------------------------
// idle_time_monitor: idle time measurement from activation events
// Align and measure: the event goes straight to the write state, and the
// result is loaded there once the result register is free; then idle again.
// Periodic sample: multiply, divide, multiply, divide, then write; a divide
// fault skips to the write; two 32-step divisions share one divider.
// Reset: asynchronous; align phase, 3 rounds, history and calibration zero.
// ----------------------------------------------------------------------------
module idle_time_monitor (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // spin_count[31:0], time_ms[63:32]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // next_delay_ms[9:0], idle_percent[25:10],
                                   // idle_valid[26], divide_fault[27],
                                   // init_done[28], phase_seen[30:29], zero[31]
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata  // calibration_rounds
);
    import itm_pkg::*;

    cmd_t cmd;
    sts_t sts;

    itm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .sts       (sts)
    );

    itm_dpath u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .sts      (sts),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

### tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking testbench for idle_time_monitor
// Drives activation events on the input stream and writes the calibration
// round register between runs of events. A scoreboard object keeps its own
// copy of the phase, history and calibration state, predicts each result and
// compares it field by field with what the block returns. Both stream sides
// idle at random: sender light and receiver heavy, then reversed, then none.
// ----------------------------------------------------------------------------
module tb;
    import itm_pkg::*;

    // Expected contents of one result transaction
    typedef struct {
        logic [DelayW-1:0] delay;
        logic [PctW-1:0]   pct;
        logic              valid;
        logic              fault;
        logic              done;
        phase_t            seen;
    } idle_report_t;

    // Tracks calibration and sampling state, queues the expected reports
    class idle_tracker;
        logic [RoundsW-1:0] rounds_reg;
        logic [RoundsW-1:0] rounds_left;
        phase_t             phase;
        logic [DataW-1:0]   prev_spins;
        logic [DataW-1:0]   prev_time;
        logic [DataW-1:0]   calib_spins;
        logic [DataW-1:0]   calib_interval;
        idle_report_t       expected_reports[$];
        int                 errors;

        function new();
            rounds_reg     = RoundsReset;
            rounds_left    = RoundsReset;
            phase          = PH_ALIGN;
            prev_spins     = '0;
            prev_time      = '0;
            calib_spins    = '0;
            calib_interval = '0;
            errors         = 0;
        endfunction

        // Register write also reloads the round counter
        function void load_rounds(logic [RoundsW-1:0] value);
            rounds_reg  = value;
            rounds_left = value;
        endfunction

        function int pending();
            return expected_reports.size();
        endfunction

        // Accepted input transaction: advance state, queue the report
        function void note_event(logic [DataW-1:0] spins, logic [DataW-1:0] now);
            idle_report_t     rep;
            logic [DataW-1:0] ds;
            logic [DataW-1:0] dt;
            logic [DataW-1:0] x;

            rep.delay = DelayAlign;
            rep.pct   = '0;
            rep.valid = 1'b0;
            rep.fault = 1'b0;
            rep.done  = 1'b0;
            rep.seen  = PH_ALIGN;
            ds = spins - prev_spins;
            dt = now - prev_time;

            case (phase)
                PH_MEASURE:
                begin
                    rep.seen       = PH_MEASURE;
                    calib_spins    = ds;
                    calib_interval = dt;
                    rounds_left    = rounds_left - 8'd1;
                    if (rounds_left != '0)
                    begin
                        phase     = PH_ALIGN;
                        rep.delay = DelayShort;
                    end
                    else
                    begin
                        phase     = PH_SAMPLE;
                        rep.delay = DelayLong;
                        rep.done  = 1'b1;
                    end
                end
                PH_SAMPLE:
                begin
                    rep.seen  = PH_SAMPLE;
                    rep.delay = DelayLong;
                    if (dt == '0 || calib_spins == '0)
                    begin
                        rep.fault = 1'b1;
                    end
                    else
                    begin
                        // every intermediate wraps at 32 bits
                        x = ds * calib_interval;
                        x = x / dt;
                        x = x * PercentScale;
                        x = x / calib_spins;
                        rep.pct   = x[PctW-1:0];
                        rep.valid = 1'b1;
                    end
                end
                default:
                begin
                    phase = PH_MEASURE;
                end
            endcase

            prev_spins = spins;
            prev_time  = now;
            expected_reports.push_back(rep);
        endfunction

        function void cmp_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                $error("%s expected %0d got %0d", name, want, got);
                errors++;
            end
        endfunction

        // Accepted result transaction against the oldest expectation
        function void check_report(logic [31:0] word);
            idle_report_t want;

            if (expected_reports.size() == 0)
            begin
                $error("result %h with no expectation pending", word);
                errors++;
                return;
            end
            want = expected_reports.pop_front();
            cmp_field("next_delay_ms", 32'(want.delay), 32'(word[9:0]));
            cmp_field("idle_percent", 32'(want.pct), 32'(word[25:10]));
            cmp_field("idle_valid", 32'(want.valid), 32'(word[26]));
            cmp_field("divide_fault", 32'(want.fault), 32'(word[27]));
            cmp_field("init_done", 32'(want.done), 32'(word[28]));
            cmp_field("phase_seen", 32'(want.seen), 32'(word[30:29]));
            cmp_field("pad", 32'd0, 32'(word[31]));
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;    // spin_count[31:0], time_ms[63:32]
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;    // next_delay_ms[9:0], idle_percent[25:10], idle_valid[26],
                             // divide_fault[27], init_done[28], phase_seen[30:29]
    logic        cfg_we;
    logic [7:0]  cfg_wdata;

    idle_tracker      book;
    int               send_idle;
    int               recv_idle;
    int               sent;
    int               cycles;
    logic [DataW-1:0] last_spins;
    logic [DataW-1:0] last_ms;
    logic [DataW-1:0] cal_ds;
    logic [DataW-1:0] cal_dt;

    localparam int CycleLimit = 400000;
    localparam int SettleCycles = 100;

    idle_time_monitor dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver back-pressure
    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= recv_idle);
    end

    // Result monitor
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            book.check_report(m_tdata);
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CycleLimit)
        begin
            $display("[idle_time_monitor] ERROR");
            $finish;
        end
    end

    // One input transaction, with random gaps ahead of it
    task automatic send_event(input logic [DataW-1:0] spins, input logic [DataW-1:0] now);
        while ($urandom_range(99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {now, spins};
        do @(posedge clk); while (!s_tready);
        book.note_event(spins, now);
        last_spins = spins;
        last_ms    = now;
        sent++;
        // idle profile follows progress through the stimulus
        if (sent < 210)
        begin
            send_idle = 27;
            recv_idle = 80;
        end
        else if (sent < 420)
        begin
            send_idle = 80;
            recv_idle = 27;
        end
        else
        begin
            send_idle = 0;
            recv_idle = 0;
        end
    endtask

    // Align then measure with the given deltas
    task automatic send_round(input logic [DataW-1:0] a_spins, input logic [DataW-1:0] a_time,
                              input logic [DataW-1:0] d_spins, input logic [DataW-1:0] d_time);
        send_event(a_spins, a_time);
        send_event(a_spins + d_spins, a_time + d_time);
    endtask

    // Stop sending and wait until every result is back and the block is quiet
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (book.pending() != 0)
            @(posedge clk);
        repeat (SettleCycles) @(posedge clk);
    endtask

    task automatic write_rounds(input logic [RoundsW-1:0] value);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        book.load_rounds(value);
        cfg_we    <= 1'b0;
    endtask

    task automatic random_rounds(input int count);
        int pick;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 50)
                send_round($urandom, $urandom, $urandom_range(5000000, 0),
                           $urandom_range(200, 0));
            else
                send_round($urandom, $urandom, $urandom, $urandom);
        end
    endtask

    task automatic random_samples(input int count);
        int               pick;
        logic [DataW-1:0] dt;
        longint unsigned  span;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
            begin
                // plausible load: spins up to about 120% of the calibrated rate
                dt   = $urandom_range(2000, 1);
                span = (longint'(cal_ds) * dt) / cal_dt;
                span = span + span / 5;
                if (span > 64'hFFFF_FFFF)
                    span = 64'hFFFF_FFFF;
                send_event(last_spins + $urandom_range(span[31:0], 0), last_ms + dt);
            end
            else if (pick < 78)
                send_event(last_spins + $urandom, last_ms);
            else
                send_event($urandom, $urandom);
        end
    endtask

    initial
    begin
        book       = new();
        send_idle  = 27;
        recv_idle  = 80;
        sent       = 0;
        cycles     = 0;
        last_spins = '0;
        last_ms    = '0;
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        m_tready  <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset value of three rounds: two rounds with extreme inputs
        send_round(32'h0, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_round(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h1, 32'h1);

        // Largest round count, then zero (counter wraps to 255 on first measure)
        write_rounds(8'd255);
        random_rounds(50);
        write_rounds(8'd0);
        random_rounds(60);

        // One round left: final calibration with a realistic rate
        write_rounds(8'd1);
        cal_ds = $urandom_range(5000000, 1000);
        cal_dt = $urandom_range(150, 50);
        send_round($urandom, $urandom, cal_ds, cal_dt);

        // Directed samples: tenfold spins, zero interval, no spins, overflow, wraps
        send_event(last_spins + cal_ds * 10, last_ms + 1000);
        send_event(last_spins + 5, last_ms);
        send_event(last_spins, last_ms + 1000);
        send_event(last_spins + cal_ds * 10, last_ms + 1);
        send_event(32'hFFFF_FF00, last_ms + 1000);
        send_event(32'h0000_0100, last_ms + 500);
        send_event(last_spins + 1000, 32'hFFFF_FFF0);
        send_event(last_spins + 1000, 32'h0000_0010);
        send_event(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_event(32'h0, 32'h0);
        send_event(last_spins - 1, last_ms + 3);

        random_samples(200);

        // A write once sampling runs must not restart calibration
        write_rounds(8'($urandom_range(255, 1)));
        random_samples(200);

        settle();
        if (book.errors == 0)
            $display("[idle_time_monitor] OK");
        else
            $display("[idle_time_monitor] ERROR");
        $finish;
    end

endmodule
